// ===== rtl/rtd_pkg.sv =====
// Package for the tile map run-length decoder.
// Holds the decoder phase encoding, the result record and the run header base.
// No dependencies.
`default_nettype none

package rtd_pkg;

  localparam int unsigned POS_W = 12;
  localparam int unsigned IDX_W = 11;
  localparam logic [7:0] RUN_BASE = 8'd128;

  typedef enum logic [3:0] {
    PH_HEADER  = 4'b0001,
    PH_RUN     = 4'b0010,
    PH_LITERAL = 4'b0100,
    PH_DONE    = 4'b1000
  } phase_t;

  typedef struct packed {
    logic             last;
    logic [7:0]       repeat_count;
    logic [IDX_W-1:0] first_index;
    logic [7:0]       tile_value;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/rle_tile_map_decoder.sv =====
// Run-length decoder for one tile map, one compressed byte per item.
//
// Input channel s_*: s_tdata carries the stream byte, s_tuser marks the first
// byte of a new map, which restarts decoding at position zero. A header byte
// above 128 makes the next byte a run value repeated (header - 128) times; a
// header from 1 to 128 is followed by that many literal bytes; zero is skipped.
// Output channel m_*: one result per run value or literal byte, with the tile
// value, the index of its first tile and the repeat count, clipped so that the
// map never passes the tile limit. m_tlast marks the result that reaches it;
// bytes after that are dropped until the next map start.
// Configuration: cfg_we writes cfg_wdata into the tile limit, capped at
// MAX_TILES. Write it only while the decoder is idle.
// Each accepted byte's result is registered in the output stage for m_*. One
// byte is accepted every cycle while s_tready is high; the decode step is a
// single compare and add on the output position. A two-entry output stage
// absorbs one result of receiver stall; s_tready drops only when both are full.
// Reset clears the limit to zero and the decoder to wait for a header.
// Depends on rtd_pkg and rtd_skid.
`default_nettype none

module rle_tile_map_decoder
  import rtd_pkg::*;
#(
  parameter int unsigned MAX_TILES = 2048
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // code_byte
  input  wire logic        s_tuser,   // start_map
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // tile_value, first_index, repeat_count, zero pad
  output logic             m_tlast,   // last
  input  wire logic        cfg_we,
  input  wire logic [11:0] cfg_wdata  // tile_limit
);

  localparam int unsigned LimCap = (MAX_TILES > 4095) ? 4095 : MAX_TILES;
  localparam logic [POS_W-1:0] LIM_CAP = POS_W'(LimCap);

  logic [POS_W-1:0] tile_limit;
  phase_t           phase, phase_next;
  logic [7:0]       pending, pending_next;
  logic [POS_W-1:0] position, position_next;

  logic [POS_W-1:0] lim;
  phase_t           ph0;
  logic [7:0]       pend0;
  logic [POS_W-1:0] pos0;
  logic [POS_W-1:0] room;
  logic [7:0]       cnt;
  logic [POS_W:0]   sum;
  logic             fin;
  logic             emit;
  logic             accept;
  logic             push;
  result_t          res;
  result_t          out_res;

  assign lim    = (tile_limit > LIM_CAP) ? LIM_CAP : tile_limit;
  assign ph0    = s_tuser ? PH_HEADER : phase;
  assign pend0  = s_tuser ? 8'd0 : pending;
  assign pos0   = s_tuser ? '0 : position;
  assign room   = lim - pos0;

  always_comb begin
    cnt = 8'd1;
    if (ph0 == PH_RUN) begin
      cnt = ({4'd0, pend0} < room) ? pend0 : room[7:0];
    end
  end

  assign sum = {1'b0, pos0} + {5'd0, cnt};
  assign fin = sum >= {1'b0, lim};

  always_comb begin
    phase_next    = ph0;
    pending_next  = pend0;
    position_next = pos0;
    emit          = 1'b0;
    if (ph0 != PH_DONE && pos0 >= lim) begin
      phase_next = PH_DONE;
    end else begin
      case (ph0)
        PH_HEADER: begin
          if (s_tdata > RUN_BASE) begin
            pending_next = s_tdata - RUN_BASE;
            phase_next   = PH_RUN;
          end else if (s_tdata != 8'd0) begin
            pending_next = s_tdata;
            phase_next   = PH_LITERAL;
          end
        end
        PH_RUN: begin
          pending_next = 8'd0;
          if (cnt == 8'd0) begin
            phase_next = PH_HEADER;
          end else begin
            emit          = 1'b1;
            position_next = sum[POS_W-1:0];
            phase_next    = fin ? PH_DONE : PH_HEADER;
          end
        end
        PH_LITERAL: begin
          emit          = 1'b1;
          position_next = sum[POS_W-1:0];
          if (fin) begin
            pending_next = 8'd0;
            phase_next   = PH_DONE;
          end else begin
            pending_next = (pend0 > 8'd0) ? pend0 - 8'd1 : 8'd0;
            if (pending_next == 8'd0) begin
              phase_next = PH_HEADER;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign accept = s_tvalid && s_tready;
  assign push   = accept && emit;

  assign res.tile_value   = s_tdata;
  assign res.first_index  = pos0[IDX_W-1:0];
  assign res.repeat_count = cnt;
  assign res.last         = fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      tile_limit <= '0;
      phase      <= PH_HEADER;
      pending    <= 8'd0;
      position   <= '0;
    end else begin
      if (cfg_we) begin
        tile_limit <= cfg_wdata;
      end
      if (accept) begin
        phase    <= phase_next;
        pending  <= pending_next;
        position <= position_next;
      end
    end
  end

  rtd_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (res),
    .has_room  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_res)
  );

  assign m_tdata = {5'd0, out_res.repeat_count, out_res.first_index, out_res.tile_value};
  assign m_tlast = out_res.last;

  a_run_pending : assert property (@(posedge clk) disable iff (rst)
    phase == PH_RUN |-> pending != 8'd0)
    else $error("run phase entered with no repeat count");

  a_last_done : assert property (@(posedge clk) disable iff (rst)
    push && res.last |=> phase == PH_DONE)
    else $error("final result did not end the map");

  a_count_nonzero : assert property (@(posedge clk) disable iff (rst)
    push |-> res.repeat_count != 8'd0)
    else $error("result with zero repeat count");

  a_done_silent : assert property (@(posedge clk) disable iff (rst)
    accept && !s_tuser && phase == PH_DONE |-> !push)
    else $error("result produced after the map was complete");

endmodule

`default_nettype wire

// ===== rtl/rtd_skid.sv =====
// Two-entry output stage for decoded results.
// Holds a result for the receiver and one more in a skid register.
// Depends on rtd_pkg for the result record.
`default_nettype none

module rtd_skid
  import rtd_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire result_t push_data,
  output logic         has_room,
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      out_data
);

  logic    skid_valid;
  result_t skid_data;
  logic    pop;

  assign has_room = !skid_valid;
  assign pop      = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop || !out_valid) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else begin
        out_data <= push_data;
      end
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

`default_nettype wire
